>>> rtl/core/lmds_pkg.sv
// Shared types, codes and defaults for the double-buffered LED matrix scanner.
`timescale 1ns / 1ps
package lmds_pkg;

  localparam int COLUMNS_DEF = 64;
  localparam int ROWS_DEF    = 16;

  localparam logic [7:0] FILL_BYTE = 8'h05;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_SWAP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_IO    = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  localparam int FLAG_RAISE_ON  = 0;
  localparam int FLAG_RAISE_OFF = 1;
  localparam int FLAG_LOWER_ON  = 2;
  localparam int FLAG_LOWER_OFF = 3;
  localparam int FLAG_TX        = 4;
  localparam int FLAG_RX        = 5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] write_word;
    logic [5:0]  control_flags;
  } req_t;

  typedef struct packed {
    logic        scan_valid;
    logic [63:0] row_bits;
    logic [3:0]  row_select;
    logic        run_indicator;
    logic        raise_pin;
    logic        lower_pin;
    logic        bus_direction;
  } rsp_t;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_CLEAR,
    S_WRITE,
    S_READ,
    S_TAIL,
    S_APPLY,
    S_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic fill;
    logic fill_init;
    logic wr_byte;
    logic rd_issue;
    logic apply;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic byte_last;
    logic read_last;
  } stat_t;

endpackage

>>> rtl/core/lmds_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lmds_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lmds_ctrl.sv
// State machine: reset fill, clear sweep, byte writes, row reads, apply and response.
`timescale 1ns / 1ps
module lmds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          opcode,
  input  lmds_pkg::stat_t     stat,
  output logic                busy,
  output lmds_pkg::cmd_t      cmd
);

  lmds_pkg::state_t state;
  lmds_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmds_pkg::S_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lmds_pkg::S_FILL: begin
        if (stat.fill_last) state_next = lmds_pkg::S_IDLE;
      end
      lmds_pkg::S_IDLE: begin
        if (start) begin
          case (opcode)
            lmds_pkg::OP_CLEAR: state_next = lmds_pkg::S_CLEAR;
            lmds_pkg::OP_WRITE: state_next = lmds_pkg::S_WRITE;
            lmds_pkg::OP_TICK:  state_next = lmds_pkg::S_READ;
            default:            state_next = lmds_pkg::S_APPLY;
          endcase
        end
      end
      lmds_pkg::S_CLEAR: begin
        if (stat.fill_last) state_next = lmds_pkg::S_RESP;
      end
      lmds_pkg::S_WRITE: begin
        if (stat.byte_last) state_next = lmds_pkg::S_RESP;
      end
      lmds_pkg::S_READ: begin
        if (stat.read_last) state_next = lmds_pkg::S_TAIL;
      end
      lmds_pkg::S_TAIL:  state_next = lmds_pkg::S_RESP;
      lmds_pkg::S_APPLY: state_next = lmds_pkg::S_RESP;
      lmds_pkg::S_RESP:  state_next = lmds_pkg::S_IDLE;
      default:           state_next = lmds_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      lmds_pkg::S_FILL: begin
        cmd.fill      = 1'b1;
        cmd.fill_init = 1'b1;
      end
      lmds_pkg::S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      lmds_pkg::S_CLEAR: cmd.fill     = 1'b1;
      lmds_pkg::S_WRITE: cmd.wr_byte  = 1'b1;
      lmds_pkg::S_READ:  cmd.rd_issue = 1'b1;
      lmds_pkg::S_APPLY: cmd.apply    = 1'b1;
      lmds_pkg::S_RESP:  cmd.respond  = 1'b1;
      default:           cmd          = '0;
    endcase
  end

endmodule

>>> rtl/core/lmds_datapath.sv
// Datapath: request latch, frame store access, pointers, counters, pins and result register.
`timescale 1ns / 1ps
module lmds_datapath #(
  parameter int COLUMNS = lmds_pkg::COLUMNS_DEF,
  parameter int ROWS    = lmds_pkg::ROWS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  lmds_pkg::req_t  request,
  input  lmds_pkg::cmd_t  cmd,
  output lmds_pkg::stat_t stat,
  output logic            done,
  output lmds_pkg::rsp_t  result
);

  localparam int ROW_BYTES = COLUMNS / 8;
  localparam int NB        = (COLUMNS + 7) / 8;
  localparam int FB        = ROW_BYTES * ROWS;
  localparam int DEPTH     = 2 * FB;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int PTR_W     = $clog2(FB);
  localparam logic [63:0] COL_MASK = ~(64'hFFFF_FFFF_FFFF_FFFF >> COLUMNS);

  lmds_pkg::req_t req;

  logic [ADDR_W-1:0] cnt;
  logic [PTR_W-1:0]  ptr;
  logic              front;
  logic [11:0]       tick;
  logic [3:0]        row;
  logic              raise_q;
  logic              lower_q;
  logic              dir_q;
  logic              rd_take;
  logic              rd_oor;
  logic [63:0]       rowbuf;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [ADDR_W:0]   rd_ext;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic [63:0]       scan_bits;
  logic              is_tick;

  assign stat.fill_last = (cnt == ADDR_W'(DEPTH - 1));
  assign stat.byte_last = (cnt == ADDR_W'(3));
  assign stat.read_last = (cnt == ADDR_W'(NB - 1));

  assign rd_ext = (ADDR_W + 1)'(front ? FB : 0) + (ADDR_W + 1)'(row * ROW_BYTES)
                + (ADDR_W + 1)'(cnt);
  assign raddr  = rd_ext[ADDR_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = 8'h00;
    if (cmd.fill) begin
      we    = 1'b1;
      wdata = cmd.fill_init ? lmds_pkg::FILL_BYTE : 8'h00;
    end else if (cmd.wr_byte) begin
      we    = 1'b1;
      waddr = ADDR_W'(front ? 0 : FB) + ADDR_W'(ptr);
      wdata = req.write_word[8 * cnt[1:0] +: 8];
    end
  end

  lmds_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign scan_bits = (rowbuf << (64 - 8 * NB)) & COL_MASK;
  assign is_tick   = (req.opcode == lmds_pkg::OP_TICK);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= request;
    end
    rd_oor <= (rd_ext >= (ADDR_W + 1)'(DEPTH));
    if (rd_take) begin
      rowbuf <= {rowbuf[55:0], rd_oor ? 8'hFF : ~rdata};
    end
    if (cmd.respond) begin
      result.scan_valid    <= is_tick;
      result.row_bits      <= is_tick ? scan_bits : 64'd0;
      result.row_select    <= is_tick ? row : 4'd0;
      result.run_indicator <= is_tick ? tick[11] : 1'b0;
      result.raise_pin     <= raise_q;
      result.lower_pin     <= lower_q;
      result.bus_direction <= dir_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      ptr     <= '0;
      front   <= 1'b0;
      tick    <= '0;
      row     <= '0;
      raise_q <= 1'b1;
      lower_q <= 1'b1;
      dir_q   <= 1'b0;
      rd_take <= 1'b0;
      done    <= 1'b0;
    end else begin
      rd_take <= cmd.rd_issue;
      done    <= cmd.respond;
      if (cmd.capture) begin
        cnt <= '0;
      end else if (cmd.fill || cmd.wr_byte || cmd.rd_issue) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.fill) begin
        ptr <= '0;
      end else if (cmd.wr_byte) begin
        ptr <= (ptr == PTR_W'(FB - 1)) ? '0 : ptr + 1'b1;
      end
      if (cmd.apply && req.opcode == lmds_pkg::OP_SWAP) begin
        front <= ~front;
        ptr   <= '0;
      end
      if (cmd.apply && req.opcode == lmds_pkg::OP_IO) begin
        if (req.control_flags[lmds_pkg::FLAG_RAISE_OFF]) raise_q <= 1'b0;
        else if (req.control_flags[lmds_pkg::FLAG_RAISE_ON]) raise_q <= 1'b1;
        if (req.control_flags[lmds_pkg::FLAG_LOWER_OFF]) lower_q <= 1'b0;
        else if (req.control_flags[lmds_pkg::FLAG_LOWER_ON]) lower_q <= 1'b1;
        if (req.control_flags[lmds_pkg::FLAG_RX]) dir_q <= 1'b0;
        else if (req.control_flags[lmds_pkg::FLAG_TX]) dir_q <= 1'b1;
      end
      if (cmd.respond && is_tick) begin
        tick <= tick + 1'b1;
        if (tick[3:0] == 4'hF || row == 4'(ROWS - 1)) begin
          row <= '0;
        end else begin
          row <= row + 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/led_matrix_double_buffer_scanner.sv
// Top level of the double-buffered LED matrix scanner: controller, datapath.
// Tick reads the displayed row with one byte-wide store read per cycle;
// clear sweeps the whole store, one byte cleared per cycle.
// A new request is taken in the cycle its predecessor's strobe shows.
// After reset busy stays high while the whole store (2*FRAME_BYTES bytes) fills with 0x05.
`timescale 1ns / 1ps
module led_matrix_double_buffer_scanner #(
  parameter int COLUMNS = lmds_pkg::COLUMNS_DEF,
  parameter int ROWS    = lmds_pkg::ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lmds_pkg::req_t request,
  output logic           busy,
  output logic           done,
  output lmds_pkg::rsp_t result
);

  lmds_pkg::cmd_t  cmd;
  lmds_pkg::stat_t stat;

  lmds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .opcode(request.opcode),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  lmds_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .request(request),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

>>> rtl/core/lmds_checker.sv
// Port-level checker for the LED matrix scanner, bound to the top level.
`timescale 1ns / 1ps
module lmds_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input lmds_pkg::rsp_t result
);

  a_fill_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two done strobes in a row");

  a_non_scan_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.scan_valid) |->
      (result.row_bits == 64'd0 && result.row_select == 4'd0 && !result.run_indicator))
    else $error("non-scan result carries scan fields");

endmodule

bind led_matrix_double_buffer_scanner lmds_checker u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);

>>> bench/lmds_scan_checker.sv
// Checker for the LED matrix scanner: predicts each result and compares it.
`timescale 1ns / 1ps
module lmds_scan_checker
  import lmds_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic done,
  input  rsp_t result,
  output int   errors,
  output int   outstanding
);

  localparam int ROW_BYTES   = COLUMNS / 8;
  localparam int FRAME_BYTES = ROW_BYTES * ROWS;
  localparam int MAX_REPORTS = 50;

  logic [7:0]  pixel_mem [2*FRAME_BYTES];
  logic        front_sel;
  int unsigned wr_ptr;
  logic [11:0] tick_cnt;
  logic        raise_lvl;
  logic        lower_lvl;
  logic        dir_lvl;

  rsp_t pending_rsp_q[$];
  rsp_t want_rsp;
  int   fail_count = 0;

  assign errors = fail_count;

  function automatic void reset_model();
    foreach (pixel_mem[i]) pixel_mem[i] = FILL_BYTE;
    front_sel = 1'b0;
    wr_ptr    = 0;
    tick_cnt  = '0;
    raise_lvl = 1'b1;
    lower_lvl = 1'b1;
    dir_lvl   = 1'b0;
  endfunction

  function automatic rsp_t step_matrix(req_t r);
    rsp_t        o;
    int unsigned base;
    int unsigned row;
    int unsigned idx;
    logic [7:0]  pix;
    o = '0;
    case (r.opcode)
      OP_CLEAR: begin
        foreach (pixel_mem[i]) pixel_mem[i] = '0;
        wr_ptr = 0;
      end
      OP_SWAP: begin
        front_sel = ~front_sel;
        wr_ptr    = 0;
      end
      OP_WRITE: begin
        base = front_sel ? 0 : FRAME_BYTES;
        for (int i = 0; i < 4; i++)
          pixel_mem[base + (wr_ptr + i) % FRAME_BYTES] = r.write_word[8*i +: 8];
        wr_ptr = (wr_ptr % FRAME_BYTES + 4) % FRAME_BYTES;
      end
      OP_IO: begin
        if (r.control_flags[FLAG_RAISE_ON])  raise_lvl = 1'b1;
        if (r.control_flags[FLAG_RAISE_OFF]) raise_lvl = 1'b0;
        if (r.control_flags[FLAG_LOWER_ON])  lower_lvl = 1'b1;
        if (r.control_flags[FLAG_LOWER_OFF]) lower_lvl = 1'b0;
        if (r.control_flags[FLAG_TX])        dir_lvl   = 1'b1;
        if (r.control_flags[FLAG_RX])        dir_lvl   = 1'b0;
      end
      OP_TICK: begin
        row  = tick_cnt[3:0] % ROWS;
        base = front_sel * FRAME_BYTES + row * ROW_BYTES;
        for (int c = 0; c < COLUMNS && c < 64; c++) begin
          idx = base + c / 8;
          pix = (idx < 2 * FRAME_BYTES) ? pixel_mem[idx] : 8'h00;
          o.row_bits[63 - c] = ~pix[7 - c % 8];
        end
        o.scan_valid    = 1'b1;
        o.row_select    = row[3:0];
        o.run_indicator = tick_cnt[11];
        tick_cnt        = tick_cnt + 12'd1;
      end
      default: ;
    endcase
    o.raise_pin     = raise_lvl;
    o.lower_pin     = lower_lvl;
    o.bus_direction = dir_lvl;
    return o;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      pending_rsp_q.delete();
    end else begin
      if (done) begin
        if (pending_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result with no request pending, expected none, actual %h",
                     $time, result);
        end else begin
          want_rsp = pending_rsp_q.pop_front();
          check_field("scan_valid", want_rsp.scan_valid, result.scan_valid);
          check_field("row_bits", want_rsp.row_bits, result.row_bits);
          check_field("row_select", want_rsp.row_select, result.row_select);
          check_field("run_indicator", want_rsp.run_indicator, result.run_indicator);
          check_field("raise_pin", want_rsp.raise_pin, result.raise_pin);
          check_field("lower_pin", want_rsp.lower_pin, result.lower_pin);
          check_field("bus_direction", want_rsp.bus_direction, result.bus_direction);
        end
      end
      if (start && !busy)
        pending_rsp_q.push_back(step_matrix(request));
    end
    outstanding <= pending_rsp_q.size();
  end

endmodule

>>> bench/led_matrix_double_buffer_scanner_test.sv
// Testbench top for the LED matrix scanner: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module led_matrix_double_buffer_scanner_test;
  import lmds_pkg::*;

  localparam int SWEEP_TICKS = 280;
  localparam int PHASE_ITEMS = 400;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  req_t request;
  rsp_t result;
  int   errors;
  int   outstanding;

  int gap_pct = 0;
  int n_total = 0;
  int n_tick  = 0;
  int n_write = 0;
  int n_swap  = 0;
  int n_clear = 0;
  int n_io    = 0;
  int n_spare = 0;

  led_matrix_double_buffer_scanner u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  lmds_scan_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[led_matrix_double_buffer_scanner] ERROR");
    $finish;
  end

  function automatic req_t make_req(logic [2:0] op, logic [31:0] word, logic [5:0] flags);
    req_t r;
    r.opcode        = op;
    r.write_word    = word;
    r.control_flags = flags;
    return r;
  endfunction

  function automatic logic [5:0] flag(int idx);
    return 6'(1) << idx;
  endfunction

  function automatic req_t noise_req();
    return make_req(3'($urandom_range(0, 7)), $urandom, 6'($urandom_range(0, 63)));
  endfunction

  // idle a random number of cycles, then hold the request until taken
  task automatic issue(req_t r);
    while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start   <= 1'b0;
      request <= noise_req();
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    n_total++;
    case (r.opcode)
      OP_CLEAR: n_clear++;
      OP_SWAP:  n_swap++;
      OP_WRITE: n_write++;
      OP_IO:    n_io++;
      OP_TICK:  n_tick++;
      default:  n_spare++;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_burst();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      n = $urandom_range(1, 40);
      repeat (n) issue(make_req(OP_WRITE, $urandom, 6'($urandom_range(0, 63))));
      if ($urandom_range(0, 9) < 7) issue(make_req(OP_SWAP, $urandom, 6'($urandom_range(0, 63))));
    end else if (pick < 75) begin
      n = $urandom_range(1, 24);
      repeat (n) issue(make_req(OP_TICK, $urandom, 6'($urandom_range(0, 63))));
    end else if (pick < 85) begin
      issue(make_req(OP_IO, $urandom, 6'($urandom_range(0, 63))));
    end else if (pick < 90) begin
      issue(make_req(OP_SWAP, $urandom, 6'($urandom_range(0, 63))));
    end else if (pick < 93) begin
      issue(make_req(OP_CLEAR, $urandom, 6'($urandom_range(0, 63))));
    end else if (pick < 96) begin
      issue(make_req(3'(OP_TICK + 1 + $urandom_range(0, 2)), $urandom,
                     6'($urandom_range(0, 63))));
    end else begin
      issue(noise_req());
    end
  endtask

  task automatic random_phase(int pct);
    int target;
    gap_pct = pct;
    target  = n_total + PHASE_ITEMS;
    while (n_total < target) random_burst();
    drain();
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset fill, pin conflicts, word extremes, swap, clear, unused codes
    issue(make_req(OP_TICK, '0, '0));
    issue(make_req(OP_IO, '0, flag(FLAG_RAISE_OFF) | flag(FLAG_LOWER_OFF) | flag(FLAG_TX)));
    issue(make_req(OP_IO, '0, flag(FLAG_RAISE_ON) | flag(FLAG_RAISE_OFF) |
                              flag(FLAG_LOWER_ON) | flag(FLAG_TX) | flag(FLAG_RX)));
    issue(make_req(OP_IO, '0, flag(FLAG_RAISE_ON) | flag(FLAG_LOWER_ON) |
                              flag(FLAG_LOWER_OFF) | flag(FLAG_TX)));
    issue(make_req(OP_IO, '1, '0));
    issue(make_req(OP_WRITE, 32'hFFFF_FFFF, '0));
    issue(make_req(OP_WRITE, 32'h0000_0000, '1));
    issue(make_req(OP_WRITE, 32'h8000_0001, '0));
    issue(make_req(OP_WRITE, 32'h1234_5678, '0));
    issue(make_req(OP_TICK, '0, '0));
    issue(make_req(OP_SWAP, '0, '0));
    issue(make_req(OP_TICK, '1, '1));
    issue(make_req(OP_TICK, '0, '0));
    issue(make_req(OP_WRITE, 32'hA5C3_0F81, '0));
    issue(make_req(OP_IO, '0, '1));
    for (int k = int'(OP_TICK) + 1; k < 8; k++)
      issue(make_req(3'(k), $urandom, '1));
    issue(make_req(OP_CLEAR, '0, '0));
    issue(make_req(OP_TICK, '0, '0));
    issue(make_req(OP_SWAP, '1, '0));
    issue(make_req(OP_TICK, '0, '0));
    drain();

    random_phase(34);
    random_phase(61);

    // long scan: back-to-back ticks over every row, no idling
    gap_pct = 0;
    repeat (20) issue(make_req(OP_WRITE, $urandom, '0));
    issue(make_req(OP_SWAP, '0, '0));
    repeat (SWEEP_TICKS) issue(make_req(OP_TICK, $urandom, 6'($urandom_range(0, 63))));
    drain();

    random_phase(0);

    drain();
    repeat (300) @(posedge clk);
    $display("covered %0d requests: %0d ticks, %0d writes, %0d swaps, %0d clears,",
             n_total, n_tick, n_write, n_swap, n_clear);
    $display("%0d io, %0d unused; sender idle 34%% then 61%% of cycles then never, %s",
             n_io, n_spare, "with drains and a back-to-back tick run");
    if (errors == 0 && outstanding == 0) begin
      $display("[led_matrix_double_buffer_scanner] OK");
    end else begin
      $display("[led_matrix_double_buffer_scanner] ERROR");
    end
    $finish;
  end

endmodule
